// ===== hdl/cpam_pkg.sv =====
// Shared types, constants and the microprogram for the cascaded PID axis mixer.
// Used by cpam_sequencer, cpam_datapath and cascaded_pid_axis_mixer.
package cpam_pkg;

  localparam int DATA_W   = 16;  // angle, rate, pwm, gains, correction
  localparam int ISUM_W   = 24;  // error integral and its limits
  localparam int CFG_W    = 24;  // widest register
  localparam int CFG_IDX_W = 3;
  localparam int PC_W     = 4;

  localparam logic [DATA_W-1:0] PWM_MIN_DEF = 16'd1000;
  localparam logic [DATA_W-1:0] PWM_MAX_DEF = 16'd2000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_KP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_KI       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_KD       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_KP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_KD       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_UPPER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LOWER = 3'd6;

  // microprogram addresses used as jump targets
  localparam logic [PC_W-1:0] STEP_IDLE = 4'd0;
  localparam logic [PC_W-1:0] STEP_PWM  = 4'd13;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_NO_IN,
    COND_OUT_BUSY
  } cpam_cond_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_OKP_ERR,
    MUL_OKI_SUM,
    MUL_OKD_DOUT,
    MUL_IKP_PIN,
    MUL_IKD_DIN
  } cpam_mul_t;

  typedef enum logic [1:0] {
    ACC_NOP,
    ACC_LOAD,
    ACC_ADD
  } cpam_acc_t;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_PREP,
    ALU_CLAMP,
    ALU_TRUNC,
    ALU_PIN,
    ALU_CORR,
    ALU_PWM
  } cpam_alu_t;

  typedef struct packed {
    logic            in_rdy;
    cpam_cond_t      cond;
    logic [PC_W-1:0] target;
    logic            last;
    cpam_mul_t       mul_sel;
    cpam_acc_t       acc_op;
    cpam_alu_t       alu_op;
  } cpam_ctl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } cpam_sts_t;

  localparam cpam_ctl_t CTL_NOP = '{
    in_rdy:  1'b0,
    cond:    COND_NONE,
    target:  STEP_IDLE,
    last:    1'b0,
    mul_sel: MUL_NONE,
    acc_op:  ACC_NOP,
    alu_op:  ALU_NOP
  };

  // control store: one word per step
  function automatic cpam_ctl_t ucode(input logic [PC_W-1:0] pc);
    cpam_ctl_t w;
    w = CTL_NOP;
    unique case (pc)
      4'd0: begin
        w.in_rdy = 1'b1;
        w.cond   = COND_NO_IN;
        w.target = STEP_IDLE;
      end
      4'd1: w.alu_op = ALU_PREP;
      4'd2: begin
        w.alu_op  = ALU_CLAMP;
        w.mul_sel = MUL_OKP_ERR;
      end
      4'd3: begin
        w.mul_sel = MUL_OKI_SUM;
        w.acc_op  = ACC_LOAD;
      end
      4'd4: begin
        w.mul_sel = MUL_OKD_DOUT;
        w.acc_op  = ACC_ADD;
      end
      4'd5: w.acc_op = ACC_ADD;
      4'd6: w.alu_op = ALU_TRUNC;
      4'd7: w.alu_op = ALU_PIN;
      4'd8: w.mul_sel = MUL_IKP_PIN;
      4'd9: begin
        w.mul_sel = MUL_IKD_DIN;
        w.acc_op  = ACC_LOAD;
      end
      4'd10: w.acc_op = ACC_ADD;
      4'd11: w.alu_op = ALU_TRUNC;
      4'd12: w.alu_op = ALU_CORR;
      4'd13: begin
        w.alu_op = ALU_PWM;
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_PWM;
        w.last   = 1'b1;
      end
      default: w = CTL_NOP;
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/cascaded_pid_axis_mixer.sv =====
// Top level of the cascaded PID axis mixer: sequencer plus datapath.
// Depends on cpam_pkg, cpam_sequencer and cpam_datapath.
//
// One attitude axis with two opposing motors. Each input item carries angle,
// rate, target angle and the two current PWM values; each item yields exactly
// one result: the inner-loop correction and both PWM values with the
// correction applied (A plus, B minus), clamped to [PWM_MIN, PWM_MAX]. The
// outer PID runs on angle minus target with a clamped integral and derivative
// on the angle; the inner PD runs on outer result plus rate, derivative on the
// rate. Gains are signed Q8.8, each loop sum is truncated toward zero by 256
// and saturated to 16 bits. Each item runs through a 14-step microprogram,
// from acceptance to the next acceptance, that drives one shared
// 16x25 multiplier through the five gain products. The result sits in an
// output register, so the next item is taken while it waits; only when a
// result is still unclaimed at the final step does the program hold there.
// Write gains and integral limits over the cfg port while no item is in work.
module cascaded_pid_axis_mixer #(
  parameter logic [cpam_pkg::DATA_W-1:0] PWM_MIN = cpam_pkg::PWM_MIN_DEF,
  parameter logic [cpam_pkg::DATA_W-1:0] PWM_MAX = cpam_pkg::PWM_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [cpam_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cpam_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [cpam_pkg::DATA_W-1:0] in_angle,
  input  logic signed [cpam_pkg::DATA_W-1:0] in_rate,
  input  logic signed [cpam_pkg::DATA_W-1:0] in_target_angle,
  input  logic [cpam_pkg::DATA_W-1:0]        in_pwm_a,
  input  logic [cpam_pkg::DATA_W-1:0]        in_pwm_b,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cpam_pkg::DATA_W-1:0]        out_new_pwm_a,
  output logic [cpam_pkg::DATA_W-1:0]        out_new_pwm_b,
  output logic signed [cpam_pkg::DATA_W-1:0] out_correction
);
  import cpam_pkg::*;

  cpam_ctl_t ctl;  // control word of the current step
  cpam_sts_t sts;  // jump conditions back to the sequencer

  // ready only on the idle step of the program
  assign in_ready = ctl.in_rdy;

  cpam_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  cpam_datapath #(
    .PWM_MIN (PWM_MIN),
    .PWM_MAX (PWM_MAX)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_angle        (in_angle),
    .in_rate         (in_rate),
    .in_target_angle (in_target_angle),
    .in_pwm_a        (in_pwm_a),
    .in_pwm_b        (in_pwm_b),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_new_pwm_a   (out_new_pwm_a),
    .out_new_pwm_b   (out_new_pwm_b),
    .out_correction  (out_correction)
  );

endmodule

// ===== hdl/cpam_sequencer.sv =====
// Microprogram sequencer: step counter, control store lookup, conditional jumps.
// Depends on cpam_pkg.
module cpam_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  cpam_pkg::cpam_sts_t sts,
  output cpam_pkg::cpam_ctl_t ctl
);
  import cpam_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            jump;

  assign ctl = ucode(pc_r);

  always_comb begin
    case (ctl.cond)
      COND_NO_IN:    jump = !sts.in_valid;
      COND_OUT_BUSY: jump = sts.out_busy;
      default:       jump = 1'b0;
    endcase
    if (jump) begin
      pc_nxt = ctl.target;
    end else if (ctl.last) begin
      pc_nxt = STEP_IDLE;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== hdl/cpam_datapath.sv =====
// Datapath: config registers, loop state, shared multiplier, accumulator,
// saturation and the output register. Depends on cpam_pkg.
module cpam_datapath #(
  parameter logic [cpam_pkg::DATA_W-1:0] PWM_MIN = cpam_pkg::PWM_MIN_DEF,
  parameter logic [cpam_pkg::DATA_W-1:0] PWM_MAX = cpam_pkg::PWM_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cpam_pkg::cpam_ctl_t              ctl,
  output cpam_pkg::cpam_sts_t              sts,
  input  logic                             cfg_we,
  input  logic [cpam_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cpam_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             in_valid,
  input  logic signed [cpam_pkg::DATA_W-1:0] in_angle,
  input  logic signed [cpam_pkg::DATA_W-1:0] in_rate,
  input  logic signed [cpam_pkg::DATA_W-1:0] in_target_angle,
  input  logic [cpam_pkg::DATA_W-1:0]      in_pwm_a,
  input  logic [cpam_pkg::DATA_W-1:0]      in_pwm_b,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [cpam_pkg::DATA_W-1:0]      out_new_pwm_a,
  output logic [cpam_pkg::DATA_W-1:0]      out_new_pwm_b,
  output logic signed [cpam_pkg::DATA_W-1:0] out_correction
);
  import cpam_pkg::*;

  localparam int DIF_W  = DATA_W + 1;          // differences and pin
  localparam int SUM_W  = ISUM_W + 1;          // raw integral sum
  localparam int OPB_W  = SUM_W;               // multiplier operand
  localparam int PROD_W = DATA_W + OPB_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int Q_W    = ACC_W - 8;
  localparam int PWM_W  = DATA_W + 2;

  // config
  logic signed [DATA_W-1:0] okp_r, oki_r, okd_r, ikp_r, ikd_r;
  logic signed [ISUM_W-1:0] upper_r, lower_r;

  // loop state
  logic signed [ISUM_W-1:0] error_sum_r;
  logic signed [DATA_W-1:0] prev_angle_r, prev_rate_r;

  // item and working registers
  logic signed [DATA_W-1:0] ang_r, rate_r, tgt_r, corr_r;
  logic [DATA_W-1:0]        pa_r, pb_r;
  logic signed [DIF_W-1:0]  err_r, dout_r, din_r, pin_r;
  logic signed [SUM_W-1:0]  isum_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [Q_W-1:0]    q_r;

  logic                     out_valid_r;
  logic [DATA_W-1:0]        new_a_r, new_b_r;
  logic signed [DATA_W-1:0] corr_out_r;

  logic signed [DIF_W-1:0]  err_c;
  logic signed [DATA_W-1:0] gain;
  logic signed [OPB_W-1:0]  opb;
  logic signed [ACC_W-1:0]  acc_bias;
  logic signed [PWM_W-1:0]  sum_a, sum_b;
  logic                     take_in, out_busy, load_out;

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [Q_W-1:0] q);
    logic signed [Q_W-1:0] hi, lo;
    hi = Q_W'(signed'(17'sd32767));
    lo = Q_W'(signed'(-17'sd32768));
    if (q > hi) begin
      return hi[DATA_W-1:0];
    end else if (q < lo) begin
      return lo[DATA_W-1:0];
    end
    return q[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] pwm_clamp(input logic signed [PWM_W-1:0] v);
    logic signed [PWM_W-1:0] mx, mn;
    mx = signed'({2'b00, PWM_MAX});
    mn = signed'({2'b00, PWM_MIN});
    if (v > mx) begin
      return PWM_MAX;
    end else if (v < mn) begin
      return PWM_MIN;
    end
    return v[DATA_W-1:0];
  endfunction

  assign take_in  = ctl.in_rdy && in_valid;
  assign out_busy = out_valid_r && !out_ready;
  assign load_out = (ctl.alu_op == ALU_PWM) && !out_busy;
  assign sts      = '{in_valid: in_valid, out_busy: out_busy};

  assign err_c    = DIF_W'(ang_r) - DIF_W'(tgt_r);
  assign acc_bias = acc_r[ACC_W-1] ? (acc_r + ACC_W'(255)) : acc_r;
  assign sum_a    = signed'({2'b00, pa_r}) + PWM_W'(corr_r);
  assign sum_b    = signed'({2'b00, pb_r}) - PWM_W'(corr_r);

  // shared multiplier operand select
  always_comb begin
    case (ctl.mul_sel)
      MUL_OKP_ERR: begin
        gain = okp_r;
        opb  = OPB_W'(err_r);
      end
      MUL_OKI_SUM: begin
        gain = oki_r;
        opb  = OPB_W'(error_sum_r);
      end
      MUL_OKD_DOUT: begin
        gain = okd_r;
        opb  = OPB_W'(dout_r);
      end
      MUL_IKP_PIN: begin
        gain = ikp_r;
        opb  = OPB_W'(pin_r);
      end
      MUL_IKD_DIN: begin
        gain = ikd_r;
        opb  = OPB_W'(din_r);
      end
      default: begin
        gain = '0;
        opb  = '0;
      end
    endcase
  end

  // config registers and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      okp_r        <= '0;
      oki_r        <= '0;
      okd_r        <= '0;
      ikp_r        <= '0;
      ikd_r        <= '0;
      upper_r      <= '0;
      lower_r      <= '0;
      error_sum_r  <= '0;
      prev_angle_r <= '0;
      prev_rate_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_OUTER_KP:       okp_r   <= cfg_wdata[DATA_W-1:0];
          REG_OUTER_KI:       oki_r   <= cfg_wdata[DATA_W-1:0];
          REG_OUTER_KD:       okd_r   <= cfg_wdata[DATA_W-1:0];
          REG_INNER_KP:       ikp_r   <= cfg_wdata[DATA_W-1:0];
          REG_INNER_KD:       ikd_r   <= cfg_wdata[DATA_W-1:0];
          REG_INTEGRAL_UPPER: upper_r <= cfg_wdata[ISUM_W-1:0];
          REG_INTEGRAL_LOWER: lower_r <= cfg_wdata[ISUM_W-1:0];
          default: ;
        endcase
      end
      if (ctl.alu_op == ALU_PREP) begin
        prev_angle_r <= ang_r;
        prev_rate_r  <= rate_r;
      end
      if (ctl.alu_op == ALU_CLAMP) begin
        if (isum_r > SUM_W'(upper_r)) begin
          error_sum_r <= upper_r;
        end else if (isum_r < SUM_W'(lower_r)) begin
          error_sum_r <= lower_r;
        end else begin
          error_sum_r <= isum_r[ISUM_W-1:0];
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    if (take_in) begin
      ang_r  <= in_angle;
      rate_r <= in_rate;
      tgt_r  <= in_target_angle;
      pa_r   <= in_pwm_a;
      pb_r   <= in_pwm_b;
    end
    prod_r <= PROD_W'(gain) * PROD_W'(opb);
    case (ctl.acc_op)
      ACC_LOAD: acc_r <= ACC_W'(prod_r);
      ACC_ADD:  acc_r <= acc_r + ACC_W'(prod_r);
      default:  ;
    endcase
    case (ctl.alu_op)
      ALU_PREP: begin
        err_r  <= err_c;
        dout_r <= DIF_W'(ang_r) - DIF_W'(prev_angle_r);
        din_r  <= DIF_W'(rate_r) - DIF_W'(prev_rate_r);
        isum_r <= SUM_W'(error_sum_r) + SUM_W'(err_c);
      end
      ALU_TRUNC: q_r <= acc_bias[ACC_W-1:8];
      ALU_PIN:   pin_r <= DIF_W'(sat16(q_r)) + DIF_W'(rate_r);
      ALU_CORR:  corr_r <= sat16(q_r);
      ALU_PWM: begin
        if (!out_busy) begin
          new_a_r    <= pwm_clamp(sum_a);
          new_b_r    <= pwm_clamp(sum_b);
          corr_out_r <= corr_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_new_pwm_a  = new_a_r;
  assign out_new_pwm_b  = new_b_r;
  assign out_correction = corr_out_r;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench for cascaded_pid_axis_mixer: PID/PD correction and PWM mix checker.
// Depends on cpam_pkg and the RTL top; holds its own bit-exact loop predictor.

typedef struct packed {
  logic [15:0] pwm_a;
  logic [15:0] pwm_b;
  logic [15:0] corr;
} mix_result_t;

class pid_scoreboard;
  logic signed [15:0] okp, oki, okd, ikp, ikd;
  logic signed [23:0] isum_upper, isum_lower;
  longint err_integral, last_angle, last_rate;
  mix_result_t pending[$];
  int errors;

  function new();
    okp = '0; oki = '0; okd = '0; ikp = '0; ikd = '0;
    isum_upper = '0; isum_lower = '0;
    err_integral = 0; last_angle = 0; last_rate = 0;
    errors = 0;
  endfunction

  function void set_reg(input logic [2:0] idx, input logic [23:0] val);
    case (idx)
      cpam_pkg::REG_OUTER_KP:       okp = val[15:0];
      cpam_pkg::REG_OUTER_KI:       oki = val[15:0];
      cpam_pkg::REG_OUTER_KD:       okd = val[15:0];
      cpam_pkg::REG_INNER_KP:       ikp = val[15:0];
      cpam_pkg::REG_INNER_KD:       ikd = val[15:0];
      cpam_pkg::REG_INTEGRAL_UPPER: isum_upper = val;
      cpam_pkg::REG_INTEGRAL_LOWER: isum_lower = val;
      default: ;
    endcase
  endfunction

  // divide by 256 toward zero, then saturate to int16
  function longint q8_sat(input longint acc);
    longint q;
    q = acc / 256;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  function logic [15:0] pwm_limit(input longint v);
    longint c;
    c = v;
    if (c > longint'(cpam_pkg::PWM_MAX_DEF)) c = longint'(cpam_pkg::PWM_MAX_DEF);
    else if (c < longint'(cpam_pkg::PWM_MIN_DEF)) c = longint'(cpam_pkg::PWM_MIN_DEF);
    return 16'(c);
  endfunction

  function void note_input(input logic signed [15:0] angle, input logic signed [15:0] rate,
                           input logic signed [15:0] target, input logic [15:0] pa,
                           input logic [15:0] pb);
    longint ang, rt, err, sum, dang, outer, pin, drt, corr;
    mix_result_t r;
    ang = longint'(angle);
    rt  = longint'(rate);
    err = ang - longint'(target);
    // upper limit wins the test order even when the limits are inverted
    sum = err_integral + err;
    if (sum > longint'(isum_upper)) sum = longint'(isum_upper);
    else if (sum < longint'(isum_lower)) sum = longint'(isum_lower);
    err_integral = sum;
    dang  = ang - last_angle;
    outer = q8_sat(longint'(okp) * err + longint'(oki) * err_integral
                   + longint'(okd) * dang);
    last_angle = ang;
    pin  = outer + rt;
    drt  = rt - last_rate;
    corr = q8_sat(longint'(ikp) * pin + longint'(ikd) * drt);
    last_rate = rt;
    r.pwm_a = pwm_limit(longint'(pa) + corr);
    r.pwm_b = pwm_limit(longint'(pb) - corr);
    r.corr  = 16'(corr);
    pending.push_back(r);
  endfunction

  function void check_result(input logic [15:0] pwm_a, input logic [15:0] pwm_b,
                             input logic [15:0] corr);
    mix_result_t want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("tb: result with nothing pending: pwm_a=%0d pwm_b=%0d corr=%0d",
                 pwm_a, pwm_b, $signed(corr));
      return;
    end
    want = pending.pop_front();
    if (pwm_a !== want.pwm_a || pwm_b !== want.pwm_b || corr !== want.corr) begin
      errors++;
      if (errors <= 10)
        $display("tb: mismatch pwm_a exp %0d got %0d, pwm_b exp %0d got %0d, corr exp %0d got %0d",
                 want.pwm_a, pwm_a, want.pwm_b, pwm_b, $signed(want.corr), $signed(corr));
    end
  endfunction
endclass

module tb;
  import cpam_pkg::*;

  localparam int HOLD_CYCLES     = 400;  // long receiver hold-off to back up the block
  localparam int ITEMS_PER_PHASE = 110;  // six random phases, 660 items
  localparam int SETTLE_CYCLES   = 16;   // a bit more than one 14-step item

  typedef enum {
    SET_DIR_A,
    SET_DIR_B,
    SET_MODERATE,
    SET_FULL,
    SET_ZERO,
    SET_EXTREME,
    SET_SMALL
  } setting_kind_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]         cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] in_angle = '0;
  logic signed [DATA_W-1:0] in_rate = '0;
  logic signed [DATA_W-1:0] in_target_angle = '0;
  logic [DATA_W-1:0]        in_pwm_a = '0;
  logic [DATA_W-1:0]        in_pwm_b = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [DATA_W-1:0]        out_new_pwm_a;
  logic [DATA_W-1:0]        out_new_pwm_b;
  logic signed [DATA_W-1:0] out_correction;

  pid_scoreboard sb = new();

  logic [CFG_W-1:0] setting [7];  // register image for the next phase
  int idle_pct = 30;              // idle burst likelihood, both sides; 0 = no idling
  bit hold_req = 1'b0;            // one-shot request for the long receiver hold-off

  cascaded_pid_axis_mixer uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_angle        (in_angle),
    .in_rate         (in_rate),
    .in_target_angle (in_target_angle),
    .in_pwm_a        (in_pwm_a),
    .in_pwm_b        (in_pwm_b),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_new_pwm_a   (out_new_pwm_a),
    .out_new_pwm_b   (out_new_pwm_b),
    .out_correction  (out_correction)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Handshake monitor. Samples at the edge, before the edge's NBAs land, so
  // both sides see the same pre-edge valid/ready values.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_input(in_angle, in_rate, in_target_angle, in_pwm_a, in_pwm_b);
      if (out_valid && out_ready)
        sb.check_result(out_new_pwm_a, out_new_pwm_b, out_correction);
    end
  end

  // Result sink: random stall bursts, plus one long hold-off on request.
  // Exactly one NBA to out_ready per edge.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(199) < idle_pct) begin
        stall_left = $urandom_range(16);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one item, optionally after an idle burst, and wait for acceptance.
  // Returns on the accepting edge; valid stays up if the next item follows.
  task automatic send_item(input logic signed [15:0] angle, input logic signed [15:0] rate,
                           input logic signed [15:0] target, input logic [15:0] pa,
                           input logic [15:0] pb);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_angle        <= angle;
    in_rate         <= rate;
    in_target_angle <= target;
    in_pwm_a        <= pa;
    in_pwm_b        <= pb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Mostly plausible control samples (angle near target, PWM around the
  // limits), the rest raw full-range noise to hit every bit.
  task automatic send_random_item();
    int target, angle, rate, pa, pb;
    if ($urandom_range(2) == 0) begin
      send_item(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      target = int'($urandom_range(4000)) - 2000;
      angle  = target + int'($urandom_range(600)) - 300;
      rate   = int'($urandom_range(800)) - 400;
      pa     = $urandom_range(800, 2200);
      pb     = $urandom_range(800, 2200);
      send_item(16'(angle), 16'(rate), 16'(target), 16'(pa), 16'(pb));
    end
  endtask

  // Stop offering, let every pending result drain, then give the block time
  // to settle before any register write. The first edge lets the monitor
  // log the last accepted item.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // gain with random junk in the unused top byte; gains use bits 15:0 only
  function automatic logic [CFG_W-1:0] rand_gain(input int span);
    return {8'($urandom), 16'(int'($urandom_range(2 * span)) - span)};
  endfunction

  // Build a register image and write it, all seven registers back to back.
  task automatic choose_setting(input setting_kind_t kind);
    int i, lim;
    case (kind)
      SET_DIR_A: begin
        setting[REG_OUTER_KP]       = 24'h000100;   // 1.0
        setting[REG_OUTER_KI]       = 24'h000020;
        setting[REG_OUTER_KD]       = 24'h00FFC0;   // -0.25
        setting[REG_INNER_KP]       = 24'h000180;
        setting[REG_INNER_KD]       = 24'h000080;
        setting[REG_INTEGRAL_UPPER] = 24'd2000;
        setting[REG_INTEGRAL_LOWER] = -24'sd2000;
      end
      SET_DIR_B: begin
        // extreme gains, inverted integral limits
        setting[REG_OUTER_KP]       = 24'h008000;
        setting[REG_OUTER_KI]       = 24'h007FFF;
        setting[REG_OUTER_KD]       = 24'h007FFF;
        setting[REG_INNER_KP]       = 24'h008000;
        setting[REG_INNER_KD]       = 24'h007FFF;
        setting[REG_INTEGRAL_UPPER] = -24'sd100;
        setting[REG_INTEGRAL_LOWER] = 24'd100;
      end
      SET_MODERATE: begin
        for (i = int'(REG_OUTER_KP); i <= int'(REG_INNER_KD); i++)
          setting[i] = rand_gain(512);
        lim = $urandom_range(200000);
        setting[REG_INTEGRAL_UPPER] = 24'(lim);
        setting[REG_INTEGRAL_LOWER] = 24'(-int'($urandom_range(200000)));
      end
      SET_FULL: begin
        for (i = int'(REG_OUTER_KP); i <= int'(REG_INTEGRAL_LOWER); i++)
          setting[i] = 24'($urandom);
      end
      SET_ZERO: begin
        for (i = int'(REG_OUTER_KP); i <= int'(REG_INTEGRAL_LOWER); i++)
          setting[i] = '0;
      end
      SET_EXTREME: begin
        for (i = int'(REG_OUTER_KP); i <= int'(REG_INNER_KD); i++)
          setting[i] = $urandom_range(1) ? 24'h007FFF : 24'hFF8000;
        setting[REG_INTEGRAL_UPPER] = 24'h7FFFFF;
        setting[REG_INTEGRAL_LOWER] = 24'h800000;
      end
      default: begin
        // SET_SMALL: fine gains, tight integral window
        for (i = int'(REG_OUTER_KP); i <= int'(REG_INNER_KD); i++)
          setting[i] = rand_gain(64);
        setting[REG_INTEGRAL_UPPER] = 24'($urandom_range(300));
        setting[REG_INTEGRAL_LOWER] = 24'(-int'($urandom_range(300)));
      end
    endcase
    for (i = int'(REG_OUTER_KP); i <= int'(REG_INTEGRAL_LOWER); i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= setting[i];
      sb.set_reg(CFG_IDX_W'(i), setting[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input setting_kind_t kind, input int pct, input bit hold);
    choose_setting(kind);
    idle_pct = pct;
    if (hold) hold_req = 1'b1;  // sender keeps offering through the hold-off
    repeat (ITEMS_PER_PHASE) send_random_item();
    drain();
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: unit-ish gains, symmetric integral window
    idle_pct = 30;
    choose_setting(SET_DIR_A);
    send_item(0, 0, 0, 1500, 1500);
    send_item(32767, 0, -32768, 0, 65535);        // max error, integral pinned high
    send_item(-32768, 0, 32767, 65535, 0);        // min error, integral pinned low
    send_item(100, 0, 100, 1000, 2000);
    send_item(0, 32767, 0, 1500, 1500);           // rate extremes
    send_item(0, -32768, 0, 1500, 1500);
    send_item(10, 5, 0, 1990, 1010);              // small correction past PWM limits
    send_item(0, 0, 0, 999, 2001);
    send_item(0, 0, 0, 2001, 999);
    send_item(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_item(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_item(-5, -3, 2, 1500, 1500);
    drain();

    // directed: extreme gains saturate both loops; lower limit above upper
    choose_setting(SET_DIR_B);
    send_item(50, 0, 0, 1500, 1500);              // sum above upper
    send_item(-500, 0, 0, 1500, 1500);            // sum below lower
    send_item(32767, 32767, 32767, 1500, 1500);
    send_item(-32768, -32768, 0, 0, 0);
    send_item(0, 0, 0, 65535, 65535);
    send_item(1, 1, 2, 1000, 1000);
    send_item(-32768, 32767, 32767, 2000, 2000);
    drain();

    // random phases; the full-range one backs the block up behind a held sink
    run_random(SET_MODERATE, 30, 1'b0);
    run_random(SET_FULL, 50, 1'b1);
    run_random(SET_ZERO, 10, 1'b0);
    run_random(SET_EXTREME, 60, 1'b0);
    run_random(SET_SMALL, 20, 1'b0);
    run_random(SET_MODERATE, 0, 1'b0);            // closing stretch, no idling

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
